// ===== design/cabp_pkg.sv =====
package cabp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_FILL_RED   = 3'd3,
        REG_FILL_GREEN = 3'd4,
        REG_FILL_BLUE  = 3'd5,
        REG_FILL_ALPHA = 3'd6
    } cfg_reg_t;

    localparam int COORD_W = 9;
    localparam int CHAN_W  = 8;
    localparam int CFG_W   = 9;

    // Packed word widths (fields padded to whole bytes)
    localparam int FIELDS_W = 2 * COORD_W + 4 * CHAN_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    // floor(2^32 / 65025): reciprocal that never overshoots the quotient
    localparam logic [16:0] RECIP_65025 = 17'd66051;
    localparam logic [15:0] DIV_65025   = 16'd65025;
    // floor(2^16 / 255)
    localparam logic [8:0]  RECIP_255   = 9'd257;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;

    localparam int PIPE_DEPTH = 5;

    // Pass-through part of a pixel; x sits in the lowest bits, alpha in the highest
    typedef struct packed {
        logic [CHAN_W-1:0]  alpha;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } pix_t;

endpackage

// ===== design/cabp_chan.sv =====
// One color channel of the over-blend:
// (255*ca*cc + da*(255-ca)*dc) / 65025, four register stages then a
// one-step correction of the reciprocal estimate.
module cabp_chan
    import cabp_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [CHAN_W-1:0] fill_alpha,
    input  logic [CHAN_W-1:0] fill_chan,
    input  logic [CHAN_W-1:0] dest_chan,
    input  logic [CHAN_W-1:0] dest_alpha,
    output logic [CHAN_W-1:0] blend
);

    logic [15:0] src_prod_reg;
    logic [15:0] dst_weight_reg;
    logic [7:0]  dc1_reg;
    logic [23:0] src_term_reg;
    logic [23:0] dst_term_reg;
    logic [23:0] sum3_reg;
    logic [23:0] sum4_reg;
    logic [7:0]  est4_reg;

    logic [40:0] recip_prod;
    logic [24:0] back_prod;
    logic [24:0] rem;

    assign recip_prod = {17'd0, sum3_reg} * {24'd0, RECIP_65025};

    // Stages 1-4: products, weighted terms, sum, quotient estimate
    always_ff @(posedge aclk) begin
        if (en) begin
            src_prod_reg   <= {8'd0, fill_alpha} * {8'd0, fill_chan};
            dst_weight_reg <= {8'd0, dest_alpha} * {8'd0, FULL_SCALE - fill_alpha};
            dc1_reg        <= dest_chan;
            src_term_reg   <= {src_prod_reg, 8'd0} - {8'd0, src_prod_reg};
            dst_term_reg   <= {8'd0, dst_weight_reg} * {16'd0, dc1_reg};
            sum3_reg       <= src_term_reg + dst_term_reg;
            sum4_reg       <= sum3_reg;
            est4_reg       <= recip_prod[39:32];
        end
    end

    // Estimate is exact or one low
    assign back_prod = {17'd0, est4_reg} * {9'd0, DIV_65025};
    assign rem       = {1'b0, sum4_reg} - back_prod;
    assign blend     = est4_reg + ((rem >= {9'd0, DIV_65025}) ? 8'd1 : 8'd0);

endmodule

// ===== design/circle_alpha_blend_pixel.sv =====
// Pipeline: an accepted s_ word reaches its m_ word through 5 register stages.
// Throughput: one pixel per cycle; all stages advance together, so the only
//   stall is a held m_ word (m_tvalid high, m_tready low), which freezes the pipe.
// Reset: synchronous, active low; clears the stage valid bits and all
//   configuration registers (circle empty, colors zero).
module circle_alpha_blend_pixel
    import cabp_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Pixel input
    input  logic               s_tvalid,
    output logic               s_tready,
    // pixel_x, pixel_y, dest_red, dest_green, dest_blue, dest_alpha, zero pad
    input  logic [TDATA_W-1:0] s_tdata,
    // Pixel output
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
    output logic [TDATA_W-1:0] m_tdata,
    // covered
    output logic               m_tuser,
    // Configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam logic [COORD_W:0] WIDTH_LIM  = (COORD_W+1)'(IMAGE_WIDTH);
    localparam logic [COORD_W:0] HEIGHT_LIM = (COORD_W+1)'(IMAGE_HEIGHT);

    // Configuration registers
    logic [COORD_W-1:0] center_x_reg, center_y_reg, radius_reg;
    logic [CHAN_W-1:0]  fill_red_reg, fill_green_reg, fill_blue_reg, fill_alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            radius_reg     <= '0;
            fill_red_reg   <= '0;
            fill_green_reg <= '0;
            fill_blue_reg  <= '0;
            fill_alpha_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:   center_x_reg   <= cfg_data;
                REG_CENTER_Y:   center_y_reg   <= cfg_data;
                REG_RADIUS:     radius_reg     <= cfg_data;
                REG_FILL_RED:   fill_red_reg   <= cfg_data[CHAN_W-1:0];
                REG_FILL_GREEN: fill_green_reg <= cfg_data[CHAN_W-1:0];
                REG_FILL_BLUE:  fill_blue_reg  <= cfg_data[CHAN_W-1:0];
                REG_FILL_ALPHA: fill_alpha_reg <= cfg_data[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: whole pipe moves unless the output word is held
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    pix_t in_pix;
    assign in_pix = s_tdata[FIELDS_W-1:0];

    // Valid bits and pass-through pixel per stage
    logic [PIPE_DEPTH-1:0] vld_reg;
    pix_t                  pix_reg [PIPE_DEPTH-1];
    pix_t                  out_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix_reg[0] <= in_pix;
            for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
                pix_reg[i] <= pix_reg[i-1];
            end
        end
    end

    // Stage 1: offsets from the center, span check on x, image bounds check, row term
    logic signed [COORD_W+1:0] dx, dy, rs;
    logic [COORD_W-1:0]        dx_abs_next;
    logic [COORD_W:0]          t_next;
    logic                      dx_ok_next, in_img_next;

    always_comb begin
        dx          = $signed({2'b00, in_pix.x}) - $signed({2'b00, center_x_reg});
        dy          = $signed({2'b00, in_pix.y}) - $signed({2'b00, center_y_reg});
        rs          = $signed({2'b00, radius_reg});
        dx_ok_next  = (dx >= -rs) && (dx < rs);
        dx_abs_next = dx[COORD_W+1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        t_next      = dy[COORD_W+1] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy + 1);
        in_img_next = ({1'b0, in_pix.x} < WIDTH_LIM) && ({1'b0, in_pix.y} < HEIGHT_LIM);
    end

    logic [COORD_W-1:0] dx_abs1_reg;
    logic [COORD_W:0]   t1_reg;
    logic               span1_reg;
    logic [17:0]        rr2_reg, dd2_reg;
    logic [18:0]        tt2_reg;
    logic               span2_reg;
    logic               cov3_reg, cov4_reg, cov5_reg;

    // Stages 1-4: squares, then the disc test by squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_abs1_reg <= dx_abs_next;
            t1_reg      <= t_next;
            span1_reg   <= dx_ok_next && in_img_next;
            rr2_reg     <= {9'd0, radius_reg} * {9'd0, radius_reg};
            dd2_reg     <= {9'd0, dx_abs1_reg} * {9'd0, dx_abs1_reg};
            tt2_reg     <= 19'({9'd0, t1_reg} * {9'd0, t1_reg});
            span2_reg   <= span1_reg;
            cov3_reg    <= span2_reg &&
                           (({1'b0, tt2_reg} + {2'b00, dd2_reg}) <= {2'b00, rr2_reg});
            cov4_reg    <= cov3_reg;
        end
    end

    // Alpha path: ca + floor(da*(255-ca)/255)
    logic [15:0] aw1_reg, aw2_reg;
    logic [7:0]  aest2_reg;
    logic [7:0]  alpha3_reg, alpha4_reg;
    logic [24:0] aw_recip;
    logic [16:0] arem;
    logic [7:0]  aq;

    assign aw_recip = {9'd0, aw1_reg} * {16'd0, RECIP_255};
    assign arem     = {1'b0, aw2_reg} - {1'b0, {8'd0, aest2_reg} * {8'd0, FULL_SCALE}};
    assign aq       = aest2_reg + ((arem >= {9'd0, FULL_SCALE}) ? 8'd1 : 8'd0);

    always_ff @(posedge aclk) begin
        if (adv) begin
            aw1_reg    <= {8'd0, in_pix.alpha} * {8'd0, FULL_SCALE - fill_alpha_reg};
            aw2_reg    <= aw1_reg;
            aest2_reg  <= aw_recip[23:16];
            alpha3_reg <= fill_alpha_reg + aq;
            alpha4_reg <= alpha3_reg;
        end
    end

    // Color channels
    logic [CHAN_W-1:0] red_blend, green_blend, blue_blend;

    cabp_chan u_chan_red (
        .aclk       (aclk),
        .en         (adv),
        .fill_alpha (fill_alpha_reg),
        .fill_chan  (fill_red_reg),
        .dest_chan  (in_pix.red),
        .dest_alpha (in_pix.alpha),
        .blend      (red_blend)
    );

    cabp_chan u_chan_green (
        .aclk       (aclk),
        .en         (adv),
        .fill_alpha (fill_alpha_reg),
        .fill_chan  (fill_green_reg),
        .dest_chan  (in_pix.green),
        .dest_alpha (in_pix.alpha),
        .blend      (green_blend)
    );

    cabp_chan u_chan_blue (
        .aclk       (aclk),
        .en         (adv),
        .fill_alpha (fill_alpha_reg),
        .fill_chan  (fill_blue_reg),
        .dest_chan  (in_pix.blue),
        .dest_alpha (in_pix.alpha),
        .blend      (blue_blend)
    );

    // Stage 5: output word, blended or passed through
    pix_t pix_out_next;

    always_comb begin
        pix_out_next = pix_reg[PIPE_DEPTH-2];
        if (cov4_reg) begin
            pix_out_next.red   = red_blend;
            pix_out_next.green = green_blend;
            pix_out_next.blue  = blue_blend;
            pix_out_next.alpha = alpha4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_pix_reg <= pix_out_next;
            cov5_reg    <= cov4_reg;
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = {{(TDATA_W-FIELDS_W){1'b0}}, out_pix_reg};
    assign m_tuser  = cov5_reg;

    // Checks
    a_cov_needs_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> radius_reg != '0)
        else $error("covered pixel with zero radius");

    a_cov_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> {1'b0, out_pix_reg.x} < WIDTH_LIM)
        else $error("covered pixel outside image");

    a_alpha_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_pix_reg.alpha >= fill_alpha_reg)
        else $error("blended alpha below fill alpha");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted word did not enter stage 1");

endmodule
